[rtl/tvpc_pkg.sv]
// Shared types and constants of the timed vibration pulse controller.
package tvpc_pkg;

  localparam int SLOT_COUNT  = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int CHAN_W      = 4;
  localparam int PWM_W       = 12;
  localparam int LEVEL_W     = 8;
  localparam int DUR_W       = 16;
  localparam int REM_W       = 9;
  localparam int LVL_C_W     = 7;
  localparam int PROD_W      = 19;
  localparam int SEL_W       = 2;

  localparam logic [LVL_C_W-1:0] LEVEL_FULL = 7'd100;

  // floor(x / 100) = floor(floor(x / 4) * RECIP_25 / 2^RECIP_SHIFT) for x < 409600
  localparam logic [17:0] RECIP_25    = 18'd167773;
  localparam int          RECIP_SHIFT = 22;

  localparam logic       OP_START  = 1'b0;
  localparam logic       OP_TICK   = 1'b1;
  localparam logic [1:0] MOTOR_ALL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_READY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd4;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pending_any;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/tvpc_cmd_if.sv]
// Command channel: start and tick items.
interface tvpc_cmd_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  motor;
  logic [7:0]  level;
  logic [15:0] pulse_ms;

  modport source (output valid, op, motor, level, pulse_ms, input ready);
  modport sink (input valid, op, motor, level, pulse_ms, output ready);
endinterface

[rtl/tvpc_res_if.sv]
// Result channel: channel writes of PWM values.
interface tvpc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic [11:0] pwm_value;
  logic        last;

  modport source (output valid, channel, pwm_value, last, input ready);
  modport sink (input valid, channel, pwm_value, last, output ready);
endinterface

[rtl/tvpc_cfg_if.sv]
// Configuration write channel.
interface tvpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tvpc_datapath.sv]
// Datapath: config registers, scaling, countdowns and the result register.
module tvpc_datapath #(
  parameter int SLOTS        = 3,
  parameter int MAX_PULSE_MS = 300
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tvpc_pkg::ctrl_cmd_t              cmd,
  output tvpc_pkg::ctrl_sts_t              sts,
  input  logic                             op,
  input  logic [1:0]                       motor,
  input  logic [tvpc_pkg::LEVEL_W-1:0]     level,
  input  logic [tvpc_pkg::DUR_W-1:0]       pulse_ms,
  input  logic                             cfg_we,
  input  logic [tvpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [tvpc_pkg::CHAN_W-1:0]      channel,
  output logic [tvpc_pkg::PWM_W-1:0]       pwm_value,
  output logic                             last
);
  import tvpc_pkg::*;

  logic                  ready_cfg;
  logic [PWM_W-1:0]      pwm_max;
  logic [CHAN_W-1:0]     chan_cfg [SLOT_COUNT];

  logic                  tick_item;
  logic [LVL_C_W-1:0]    level_c;
  logic [REM_W-1:0]      dur_c;
  logic [SLOT_COUNT-1:0] work_mask;
  logic [SLOT_COUNT-1:0] pending;
  logic [PROD_W-1:0]     prod;
  logic [PWM_W-1:0]      pwm;
  logic [REM_W-1:0]      remaining [SLOTS];
  logic                  active [SLOTS];

  logic [SLOT_COUNT-1:0] mask_next;
  logic [LVL_C_W-1:0]    level_clamp;
  logic [REM_W-1:0]      dur_clamp;
  logic [34:0]           scaled;
  logic [SEL_W-1:0]      sel_idx;
  logic [SLOT_COUNT-1:0] sel_hot;
  logic [SLOT_COUNT-1:0] pending_rest;

  assign level_clamp = (level > LEVEL_W'(LEVEL_FULL)) ? LEVEL_FULL : level[LVL_C_W-1:0];
  assign dur_clamp   = (pulse_ms > DUR_W'(MAX_PULSE_MS)) ? REM_W'(MAX_PULSE_MS)
                                                         : pulse_ms[REM_W-1:0];
  assign scaled      = 35'(prod[PROD_W-1:2]) * 35'(RECIP_25);

  always_comb begin
    mask_next = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (op == OP_TICK) begin
        mask_next[i] = active[i] && (remaining[i] <= REM_W'(1));
      end else begin
        mask_next[i] = (motor == MOTOR_ALL) || (motor == SEL_W'(i));
      end
    end
  end

  always_comb begin
    sel_idx = '0;
    sel_hot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel_idx = SEL_W'(i);
        sel_hot = '0;
        sel_hot[i] = 1'b1;
      end
    end
    pending_rest = pending & ~sel_hot;
  end

  assign sts.pending_any = |pending;
  assign sts.out_free    = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_cfg <= 1'b0;
      pwm_max   <= 12'd4095;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        chan_cfg[i] <= CHAN_W'(i);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_READY:  ready_cfg   <= cfg_data[0];
        REG_PWM:    pwm_max     <= cfg_data[PWM_W-1:0];
        REG_LEFT:   chan_cfg[0] <= cfg_data[CHAN_W-1:0];
        REG_RIGHT:  chan_cfg[1] <= cfg_data[CHAN_W-1:0];
        REG_CENTER: chan_cfg[2] <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_item <= op;
      level_c   <= level_clamp;
      dur_c     <= dur_clamp;
      work_mask <= mask_next;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(level_c) * PROD_W'(pwm_max);
    end
    if (cmd.div) begin
      pwm <= scaled[RECIP_SHIFT +: PWM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        remaining[i] <= '0;
        active[i]    <= 1'b0;
      end
    end else begin
      if (cmd.commit) begin
        pending <= work_mask & {SLOT_COUNT{ready_cfg}};
        for (int i = 0; i < SLOTS; i++) begin
          if (tick_item == OP_TICK) begin
            if (active[i]) begin
              if (remaining[i] > REM_W'(1)) begin
                remaining[i] <= remaining[i] - REM_W'(1);
              end else begin
                remaining[i] <= '0;
                active[i]    <= 1'b0;
              end
            end
          end else if (work_mask[i]) begin
            remaining[i] <= dur_c;
            active[i]    <= (pwm != '0) && (dur_c != '0);
          end
        end
      end else if (cmd.emit) begin
        pending <= pending_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      channel   <= chan_cfg[sel_idx];
      pwm_value <= (tick_item == OP_TICK) ? '0 : pwm;
      last      <= (pending_rest == '0);
    end
  end

endmodule

[rtl/tvpc_ctrl.sv]
// Controller: sequences accept, scaling, state update and result beats.
module tvpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_tick,
  output logic                in_ready,
  output tvpc_pkg::ctrl_cmd_t cmd,
  input  tvpc_pkg::ctrl_sts_t sts
);
  import tvpc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.mul    = (state == S_MUL);
  assign cmd.div    = (state == S_DIV);
  assign cmd.commit = (state == S_COMMIT);
  assign cmd.emit   = (state == S_EMIT) && sts.pending_any && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_tick == OP_TICK) ? S_COMMIT : S_MUL;
        end
      end
      S_MUL:    state_next = S_DIV;
      S_DIV:    state_next = S_COMMIT;
      S_COMMIT: state_next = S_EMIT;
      S_EMIT: begin
        if (!sts.pending_any) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/timed_vibration_pulse_controller_core.sv]
// Top level of the timed vibration pulse controller.
// Three one-shot PWM pulse timers behind a command channel (cmd), a result
// channel (res) and a configuration write channel (cfg).
// A cmd beat is either a start (motor 0..2, or 3 for all, level, duration in
// ms) or a one millisecond tick. A start gives one res beat per started motor
// with its channel and scaled duty; a tick gives one beat of duty 0 for each
// motor that expires. The final beat of an item carries last. With the ready
// register clear, state still updates but no beats are sent.
// A start passes through multiply, reciprocal divide by 100, state update and
// output register, with clamping registered at acceptance; a tick skips the
// multiply and divide. Further beats follow one per cycle while res is ready.
// One item is in work at a time; cmd.ready rises when the sequencer is back in
// idle, after the final beat of the item is loaded into the output register.
// When res stalls, the output register holds and the sequencer waits. cfg is
// always ready, writes are registered and must be made while idle (unchecked).
// Reset (synchronous) clears all countdowns and active flags and loads the
// register defaults: not ready, full scale 4095, channels 0, 1 and 2.
module timed_vibration_pulse_controller_core #(
  parameter int NUM_MOTORS   = 3,
  parameter int MAX_PULSE_MS = 300
) (
  input logic   clk,
  input logic   rst,
  tvpc_cmd_if.sink   cmd,
  tvpc_res_if.source res,
  tvpc_cfg_if.sink   cfg
);
  import tvpc_pkg::*;

  localparam int SLOTS = (NUM_MOTORS < SLOT_COUNT) ? NUM_MOTORS : SLOT_COUNT;

  ctrl_cmd_t ctl_cmd;
  ctrl_sts_t ctl_sts;
  logic      in_ready;

  assign cmd.ready = in_ready;
  assign cfg.ready = 1'b1;

  tvpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_tick  (cmd.op),
    .in_ready (in_ready),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts)
  );

  tvpc_datapath #(
    .SLOTS        (SLOTS),
    .MAX_PULSE_MS (MAX_PULSE_MS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl_cmd),
    .sts         (ctl_sts),
    .op          (cmd.op),
    .motor       (cmd.motor),
    .level       (cmd.level),
    .pulse_ms    (cmd.pulse_ms),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .channel     (res.channel),
    .pwm_value   (res.pwm_value),
    .last        (res.last)
  );

endmodule

[test/tvpc_pulse_scoreboard.sv]
// Scoreboard for the pulse controller: tracks countdowns, predicts PWM writes, checks res beats.
module tvpc_pulse_scoreboard #(
  parameter int NUM_MOTORS   = 3,
  parameter int MAX_PULSE_MS = 300
) (
  input  logic clk,
  input  logic rst,
  tvpc_cmd_if  cmd,
  tvpc_res_if  res,
  tvpc_cfg_if  cfg,
  output int   pending,
  output int   mismatches,
  output int   writes_checked
);
  import tvpc_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [PWM_W-1:0]  pwm_value;
    logic              last;
  } pwm_write_t;

  logic              drv_ready;
  logic [PWM_W-1:0]  full_scale;
  logic [CHAN_W-1:0] chan_map [SLOT_COUNT];
  logic [REM_W-1:0]  ms_left [SLOT_COUNT];
  logic              running [SLOT_COUNT];
  pwm_write_t        due_writes [$];
  int                err_cnt;
  int                seen_cnt;

  function automatic void queue_write(logic [CHAN_W-1:0] ch, logic [PWM_W-1:0] duty);
    pwm_write_t w;
    if (drv_ready) begin
      w.channel   = ch;
      w.pwm_value = duty;
      w.last      = 1'b0;
      due_writes.push_back(w);
    end
  endfunction

  function automatic void start_motor(int idx, logic [LEVEL_W-1:0] level,
                                      logic [DUR_W-1:0] dur);
    int pct;
    int ms;
    int duty;
    if (idx >= NUM_MOTORS || idx >= SLOT_COUNT) return;
    pct  = (level > LEVEL_FULL) ? int'(LEVEL_FULL) : int'(level);
    ms   = (dur > MAX_PULSE_MS) ? MAX_PULSE_MS : int'(dur);
    duty = (pct * int'(full_scale)) / int'(LEVEL_FULL);
    running[idx] = (duty > 0) && (ms > 0);
    ms_left[idx] = ms[REM_W-1:0];
    queue_write(chan_map[idx], duty[PWM_W-1:0]);
  endfunction

  function automatic void count_down();
    for (int i = 0; i < SLOT_COUNT && i < NUM_MOTORS; i++) begin
      if (running[i]) begin
        if (ms_left[i] != '0) ms_left[i] = ms_left[i] - 1'b1;
        if (ms_left[i] == '0) begin
          running[i] = 1'b0;
          queue_write(chan_map[i], '0);
        end
      end
    end
  endfunction

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    pwm_write_t want;
    int         before_n;
    if (rst) begin
      drv_ready  = 1'b0;
      full_scale = 12'd4095;
      chan_map[0] = 4'd0;
      chan_map[1] = 4'd1;
      chan_map[2] = 4'd2;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        ms_left[i] = '0;
        running[i] = 1'b0;
      end
      due_writes.delete();
      err_cnt  = 0;
      seen_cnt = 0;
    end else begin
      if (res.valid && res.ready) begin
        seen_cnt++;
        if (due_writes.size() == 0) begin
          note_error($sformatf("unexpected res beat: ch %0d pwm %0d last %0b",
                               res.channel, res.pwm_value, res.last));
        end else begin
          want = due_writes.pop_front();
          if (res.channel !== want.channel || res.pwm_value !== want.pwm_value ||
              res.last !== want.last)
            note_error($sformatf(
              "res beat mismatch: want ch %0d pwm %0d last %0b, got ch %0d pwm %0d last %0b",
              want.channel, want.pwm_value, want.last,
              res.channel, res.pwm_value, res.last));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_READY:  drv_ready   = cfg.data[0];
          REG_PWM:    full_scale  = cfg.data[PWM_W-1:0];
          REG_LEFT:   chan_map[0] = cfg.data[CHAN_W-1:0];
          REG_RIGHT:  chan_map[1] = cfg.data[CHAN_W-1:0];
          REG_CENTER: chan_map[2] = cfg.data[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        before_n = due_writes.size();
        if (cmd.op == OP_TICK) begin
          count_down();
        end else if (cmd.motor == MOTOR_ALL) begin
          for (int m = 0; m < SLOT_COUNT; m++) start_motor(m, cmd.level, cmd.pulse_ms);
        end else begin
          start_motor(int'(cmd.motor), cmd.level, cmd.pulse_ms);
        end
        if (due_writes.size() > before_n) begin
          want = due_writes.pop_back();
          want.last = 1'b1;
          due_writes.push_back(want);
        end
      end
    end
    pending        <= due_writes.size();
    mismatches     <= err_cnt;
    writes_checked <= seen_cnt;
  end

endmodule

[test/tb_timed_vibration_pulse_controller_core.sv]
// Top of the pulse controller bench: clock, reset, command and register traffic, verdict.
module tb_timed_vibration_pulse_controller_core;
  import tvpc_pkg::*;

  logic clk;
  logic rst;
  bit   no_gaps;
  int   pending;
  int   mismatches;
  int   writes_checked;
  int   cmds_sent;
  int   settings_used;

  tvpc_cmd_if cmd ();
  tvpc_res_if res ();
  tvpc_cfg_if cfg ();

  timed_vibration_pulse_controller_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg)
  );

  tvpc_pulse_scoreboard board (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .res            (res),
    .cfg            (cfg),
    .pending        (pending),
    .mismatches     (mismatches),
    .writes_checked (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // res sink: random stall before each beat, none while no_gaps is set
  initial begin
    int stall;
    res.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        res.ready <= 1'b0;
      end
      @(negedge clk);
      res.ready <= 1'b1;
      do @(posedge clk); while (res.valid !== 1'b1);
    end
  end

  task automatic send_cmd(logic op, logic [1:0] motor, logic [LEVEL_W-1:0] level,
                          logic [DUR_W-1:0] dur);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      cmd.valid <= 1'b0;
    end
    @(negedge clk);
    cmd.valid    <= 1'b1;
    cmd.op       <= op;
    cmd.motor    <= motor;
    cmd.level    <= level;
    cmd.pulse_ms <= dur;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    cmds_sent++;
  endtask

  task automatic start_pulse(logic [1:0] motor, logic [LEVEL_W-1:0] level,
                             logic [DUR_W-1:0] dur);
    send_cmd(OP_START, motor, level, dur);
  endtask

  // tick payload is don't-care, so fill it with noise
  task automatic tick_ms();
    send_cmd(OP_TICK, 2'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] rdy, logic [CFG_DATA_W-1:0] full,
                               logic [CFG_DATA_W-1:0] lch, logic [CFG_DATA_W-1:0] rch,
                               logic [CFG_DATA_W-1:0] cch);
    write_reg(REG_READY, rdy);
    write_reg(REG_PWM, full);
    write_reg(REG_LEFT, lch);
    write_reg(REG_RIGHT, rch);
    write_reg(REG_CENTER, cch);
    settings_used++;
  endtask

  task automatic random_cmd();
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   dur;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      tick_ms();
    end else begin
      case ($urandom_range(0, 5))
        0:       level = 8'd0;
        1:       level = 8'd100;
        2:       level = 8'($urandom_range(101, 255));
        default: level = 8'($urandom_range(1, 99));
      endcase
      case ($urandom_range(0, 7))
        0:       dur = 16'd0;
        1:       dur = 16'($urandom_range(290, 310));
        2:       dur = 16'($urandom);
        default: dur = 16'($urandom_range(1, 8));
      endcase
      start_pulse(2'($urandom_range(0, 3)), level, dur);
    end
  endtask

  initial begin
    rst           = 1'b1;
    no_gaps       = 1'b0;
    cmds_sent     = 0;
    settings_used = 0;
    cmd.valid     = 1'b0;
    cmd.op        = OP_START;
    cmd.motor     = '0;
    cmd.level     = '0;
    cmd.pulse_ms  = '0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_READY;
    cfg.data      = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    apply_setting(12'd1, 12'd4095, 12'd15, 12'd0, 12'd7);
    start_pulse(2'd0, 8'd0, 16'd100);
    start_pulse(2'd1, 8'd255, 16'hFFFF);
    start_pulse(2'd2, 8'd100, 16'd0);
    start_pulse(MOTOR_ALL, 8'd50, 16'd3);
    repeat (4) tick_ms();
    start_pulse(2'd0, 8'd1, 16'd1);
    start_pulse(2'd2, 8'd99, 16'd2);
    repeat (2) tick_ms();
    start_pulse(MOTOR_ALL, 8'd101, 16'd301);
    start_pulse(2'd1, 8'd0, 16'd0);
    drain();

    apply_setting(12'd1, 12'd0, 12'd0, 12'd15, 12'd0);
    start_pulse(MOTOR_ALL, 8'd100, 16'd5);
    tick_ms();
    drain();

    apply_setting(12'd1, 12'd1, 12'd3, 12'd12, 12'd9);
    start_pulse(2'd0, 8'd100, 16'd1);
    start_pulse(2'd1, 8'd99, 16'd4);
    tick_ms();
    drain();

    // countdowns keep running while writes are suppressed
    apply_setting(12'hFFE, 12'd2048, 12'd5, 12'd6, 12'd10);
    start_pulse(MOTOR_ALL, 8'd77, 16'd2);
    tick_ms();
    drain();
    write_reg(REG_READY, 12'd1);
    tick_ms();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_setting(12'd1, 12'd4095, 12'($urandom), 12'($urandom), 12'($urandom));
        1: apply_setting(12'd1, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        2: apply_setting(12'd0, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        3: apply_setting(12'd1, 12'd100, 12'd15, 12'd15, 12'd15);
        default: apply_setting({11'($urandom), 1'b1}, 12'($urandom), 12'($urandom),
                               12'($urandom), 12'($urandom));
      endcase
      for (int k = 0; k < 30; k++) begin
        if (k % 12 == 0) no_gaps = (p == 1) || ($urandom_range(0, 3) == 0);
        random_cmd();
      end
      no_gaps = 1'b0;
      drain();
    end

    $display("tb: run covered %0d commands under %0d register settings, %0d pwm writes checked",
             cmds_sent, settings_used, writes_checked);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tvpc_pkg.sv
rtl/tvpc_cmd_if.sv
rtl/tvpc_res_if.sv
rtl/tvpc_cfg_if.sv
rtl/tvpc_datapath.sv
rtl/tvpc_ctrl.sv
rtl/timed_vibration_pulse_controller_core.sv
test/tvpc_pulse_scoreboard.sv
test/tb_timed_vibration_pulse_controller_core.sv
